// File: rtl/tbo_pkg.sv
`timescale 1ns / 1ps
// tbo_pkg: shared constants, register index codes and axis index helpers
// for the triangle/box overlap block. No dependencies.
package tbo_pkg;

    localparam int HALF_W     = 31;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;

    localparam logic [HALF_W-1:0] HALF_RESET = 31'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HALF_X = 2'd0,
        REG_HALF_Y = 2'd1,
        REG_HALF_Z = 2'd2
    } cfg_reg_t;

    // next and previous axis, cyclic over x, y, z
    function automatic int nx(input int k);
        return (k == 2) ? 0 : k + 1;
    endfunction

    function automatic int pv(input int k);
        return (k == 0) ? 2 : k - 1;
    endfunction

endpackage

// File: rtl/tbo_front.sv
`timescale 1ns / 1ps
// tbo_front: accepts input beats, moves the vertices to the box center and
// forms the edges. Depends on tbo_pkg.
module tbo_front import tbo_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [W-1:0]               center_x,
    input  logic signed [W-1:0]               center_y,
    input  logic signed [W-1:0]               center_z,
    input  logic signed [W-1:0]               a_x,
    input  logic signed [W-1:0]               a_y,
    input  logic signed [W-1:0]               a_z,
    input  logic signed [W-1:0]               b_x,
    input  logic signed [W-1:0]               b_y,
    input  logic signed [W-1:0]               b_z,
    input  logic signed [W-1:0]               c_x,
    input  logic signed [W-1:0]               c_y,
    input  logic signed [W-1:0]               c_z,
    output logic                              push_valid,
    input  logic                              push_ready,
    output logic [9*(W+1)+9*(W+2)-1:0]        push_data
);

    localparam int VW = W + 1;
    localparam int EW = W + 2;

    logic                  f_vld_reg;
    logic signed [VW-1:0]  v_reg [3][3];
    logic signed [VW-1:0]  v_next [3][3];
    logic signed [EW-1:0]  e [3][3];
    logic                  accept;

    assign in_ready   = !f_vld_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = f_vld_reg;

    always_comb
    begin
        v_next[0][0] = VW'(a_x) - VW'(center_x);
        v_next[0][1] = VW'(a_y) - VW'(center_y);
        v_next[0][2] = VW'(a_z) - VW'(center_z);
        v_next[1][0] = VW'(b_x) - VW'(center_x);
        v_next[1][1] = VW'(b_y) - VW'(center_y);
        v_next[1][2] = VW'(b_z) - VW'(center_z);
        v_next[2][0] = VW'(c_x) - VW'(center_x);
        v_next[2][1] = VW'(c_y) - VW'(center_y);
        v_next[2][2] = VW'(c_z) - VW'(center_z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            f_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            v_reg <= v_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e[i][k] = EW'(v_reg[nx(i)][k]) - EW'(v_reg[i][k]);
                push_data[(i*3+k)*VW +: VW]        = v_reg[i][k];
                push_data[9*VW + (i*3+k)*EW +: EW] = e[i][k];
            end
        end
    end

endmodule

// File: rtl/tbo_queue.sv
`timescale 1ns / 1ps
// tbo_queue: short register queue between the front and back sections.
// Depends on tbo_pkg for its depth.
module tbo_queue import tbo_pkg::*;
#(
    parameter int DATA_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0]  mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != (Q_PTR_W+1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/tbo_back.sv
`timescale 1ns / 1ps
// tbo_back: separating axis tests; edge-axis products, plane normal, split
// wide dot products and the final compare. Depends on tbo_pkg.
module tbo_back import tbo_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    output logic                       q_ready,
    input  logic [9*(W+1)+9*(W+2)-1:0] q_data,
    input  logic [HALF_W-1:0]          half_x,
    input  logic [HALF_W-1:0]          half_y,
    input  logic [HALF_W-1:0]          half_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       overlap
);

    localparam int VW = W + 1;
    localparam int EW = W + 2;
    localparam int PW = EW + VW;
    localparam int AW = EW + HALF_W;
    localparam int RW = (2*W+4 > W+35) ? 2*W+4 : W+35;
    localparam int NW = 2*W + 5;
    localparam int LB = (NW + 1) / 2;
    localparam int HB = NW - LB;
    localparam int CW = ((VW > HALF_W+1) ? VW : HALF_W+1) + 1;
    localparam int DW = ((VW > HALF_W+1) ? NW+VW : NW+HALF_W+1) + 2;

    logic                 adv;
    logic signed [VW-1:0] v [3][3];
    logic signed [EW-1:0] e [3][3];
    logic [EW-1:0]        ea [3][3];
    logic [HALF_W-1:0]    h [3];
    logic signed [CW-1:0] hp [3];
    logic signed [CW-1:0] hn [3];
    logic                 sep_axis;

    logic                 s1_vld_reg;
    logic signed [PW-1:0] s1_pa_reg [9][2];
    logic signed [PW-1:0] s1_pb_reg [9][2];
    logic [AW-1:0]        s1_ra_reg [9];
    logic [AW-1:0]        s1_rb_reg [9];
    logic signed [2*EW-1:0] s1_na_reg [3];
    logic signed [2*EW-1:0] s1_nb_reg [3];
    logic signed [VW-1:0] s1_v0_reg [3];
    logic                 s1_sep_reg;

    logic                 s2_vld_reg;
    logic signed [RW-1:0] s2_p_reg [9][2];
    logic signed [RW-1:0] s2_rad_reg [9];
    logic signed [NW-1:0] s2_n_reg [3];
    logic signed [VW-1:0] s2_v0_reg [3];
    logic                 s2_sep_reg;
    logic                 sep_edge;
    logic [NW-1:0]        an [3];

    logic                       s3_vld_reg;
    logic signed [LB+VW:0]      s3_dlo_reg [3];
    logic signed [HB+VW-1:0]    s3_dhi_reg [3];
    logic [LB+HALF_W-1:0]       s3_alo_reg [3];
    logic [HB+HALF_W-1:0]       s3_ahi_reg [3];
    logic                       s3_sep_reg;

    logic                 s4_vld_reg;
    logic signed [DW-1:0] s4_dt_reg [3];
    logic signed [DW-1:0] s4_rt_reg [3];
    logic                 s4_sep_reg;

    logic                 s5_vld_reg;
    logic signed [DW-1:0] s5_ds_reg;
    logic signed [DW-1:0] s5_rs_reg;
    logic                 s5_sep_reg;

    logic                 out_valid_reg;
    logic                 overlap_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign q_ready   = adv;
    assign out_valid = out_valid_reg;
    assign overlap   = overlap_reg;

    assign h[0] = half_x;
    assign h[1] = half_y;
    assign h[2] = half_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                v[i][k]  = q_data[(i*3+k)*VW +: VW];
                e[i][k]  = q_data[9*VW + (i*3+k)*EW +: EW];
                ea[i][k] = e[i][k][EW-1] ? EW'(-e[i][k]) : EW'(e[i][k]);
            end
        end
    end

    // vertex extents along x, y, z
    always_comb
    begin
        sep_axis = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            hp[k] = CW'({1'b0, h[k]});
            hn[k] = -hp[k];
            if ((CW'(v[0][k]) > hp[k] && CW'(v[1][k]) > hp[k] && CW'(v[2][k]) > hp[k]) ||
                (CW'(v[0][k]) < hn[k] && CW'(v[1][k]) < hn[k] && CW'(v[2][k]) < hn[k]))
            begin
                sep_axis = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    s1_pa_reg[i*3+k][0] <= e[i][pv(k)] * v[i][nx(k)];
                    s1_pb_reg[i*3+k][0] <= e[i][nx(k)] * v[i][pv(k)];
                    s1_pa_reg[i*3+k][1] <= e[i][pv(k)] * v[pv(i)][nx(k)];
                    s1_pb_reg[i*3+k][1] <= e[i][nx(k)] * v[pv(i)][pv(k)];
                    s1_ra_reg[i*3+k]    <= ea[i][pv(k)] * h[nx(k)];
                    s1_rb_reg[i*3+k]    <= ea[i][nx(k)] * h[pv(k)];
                end
            end
            for (int k = 0; k < 3; k++)
            begin
                s1_na_reg[k] <= e[0][nx(k)] * e[1][pv(k)];
                s1_nb_reg[k] <= e[0][pv(k)] * e[1][nx(k)];
                s1_v0_reg[k] <= v[0][k];
            end
            s1_sep_reg <= sep_axis;

            for (int a = 0; a < 9; a++)
            begin
                s2_p_reg[a][0] <= RW'(s1_pa_reg[a][0]) - RW'(s1_pb_reg[a][0]);
                s2_p_reg[a][1] <= RW'(s1_pa_reg[a][1]) - RW'(s1_pb_reg[a][1]);
                s2_rad_reg[a]  <= $signed(RW'(s1_ra_reg[a])) + $signed(RW'(s1_rb_reg[a]));
            end
            for (int k = 0; k < 3; k++)
            begin
                s2_n_reg[k]  <= NW'(s1_na_reg[k]) - NW'(s1_nb_reg[k]);
                s2_v0_reg[k] <= s1_v0_reg[k];
            end
            s2_sep_reg <= s1_sep_reg;

            for (int k = 0; k < 3; k++)
            begin
                s3_dlo_reg[k] <= $signed({1'b0, s2_n_reg[k][LB-1:0]}) * s2_v0_reg[k];
                s3_dhi_reg[k] <= $signed(s2_n_reg[k][NW-1:LB]) * s2_v0_reg[k];
                s3_alo_reg[k] <= an[k][LB-1:0] * h[k];
                s3_ahi_reg[k] <= an[k][NW-1:LB] * h[k];
            end
            s3_sep_reg <= s2_sep_reg || sep_edge;

            for (int k = 0; k < 3; k++)
            begin
                s4_dt_reg[k] <= (DW'(s3_dhi_reg[k]) <<< LB) + DW'(s3_dlo_reg[k]);
                s4_rt_reg[k] <= $signed((DW'(s3_ahi_reg[k]) << LB) + DW'(s3_alo_reg[k]));
            end
            s4_sep_reg <= s3_sep_reg;

            s5_ds_reg  <= s4_dt_reg[0] + s4_dt_reg[1] + s4_dt_reg[2];
            s5_rs_reg  <= s4_rt_reg[0] + s4_rt_reg[1] + s4_rt_reg[2];
            s5_sep_reg <= s4_sep_reg;

            overlap_reg <= !s5_sep_reg && (s5_ds_reg <= s5_rs_reg) &&
                           (s5_ds_reg >= -s5_rs_reg);
        end
    end

    // edge-cross-axis intervals against their radii; |n| for the plane test
    always_comb
    begin
        sep_edge = 1'b0;
        for (int a = 0; a < 9; a++)
        begin
            if ((s2_p_reg[a][0] > s2_rad_reg[a] && s2_p_reg[a][1] > s2_rad_reg[a]) ||
                (s2_p_reg[a][0] < -s2_rad_reg[a] && s2_p_reg[a][1] < -s2_rad_reg[a]))
            begin
                sep_edge = 1'b1;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            an[k] = s2_n_reg[k][NW-1] ? NW'(-s2_n_reg[k]) : NW'(s2_n_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            s5_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= q_valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            out_valid_reg <= s5_vld_reg;
        end
    end

`ifndef SYNTH
    ap_pop_enters: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && adv |=> s1_vld_reg)
        else $error("popped beat did not enter the pipeline");

    ap_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        adv && s1_vld_reg |=> s2_vld_reg)
        else $error("beat lost between stage 1 and 2");

    ap_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s5_vld_reg) && $stable(s3_vld_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule

// File: rtl/triangle_box_overlap.sv
`timescale 1ns / 1ps
// Triangle versus axis-aligned box overlap by the separating axis test.
// Path: front register, queue, six back stages. Throughput: one beat per
// cycle while out_ready does not stall the result, set by the back pipeline.
// Reset clears all valid state and sets half_x, half_y, half_z to 1.0.
// Depends on tbo_pkg, tbo_front, tbo_queue, tbo_back.
module triangle_box_overlap import tbo_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] center_x,
    input  logic signed [COORD_WIDTH-1:0] center_y,
    input  logic signed [COORD_WIDTH-1:0] center_z,
    input  logic signed [COORD_WIDTH-1:0] a_x,
    input  logic signed [COORD_WIDTH-1:0] a_y,
    input  logic signed [COORD_WIDTH-1:0] a_z,
    input  logic signed [COORD_WIDTH-1:0] b_x,
    input  logic signed [COORD_WIDTH-1:0] b_y,
    input  logic signed [COORD_WIDTH-1:0] b_z,
    input  logic signed [COORD_WIDTH-1:0] c_x,
    input  logic signed [COORD_WIDTH-1:0] c_y,
    input  logic signed [COORD_WIDTH-1:0] c_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          overlap
);

    localparam int QW = 9*(COORD_WIDTH+1) + 9*(COORD_WIDTH+2);

    logic [HALF_W-1:0] half_x_reg;
    logic [HALF_W-1:0] half_y_reg;
    logic [HALF_W-1:0] half_z_reg;
    logic              push_valid;
    logic              push_ready;
    logic [QW-1:0]     push_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [QW-1:0]     pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_x_reg <= HALF_RESET;
            half_y_reg <= HALF_RESET;
            half_z_reg <= HALF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HALF_X: half_x_reg <= cfg_data[HALF_W-1:0];
                REG_HALF_Y: half_y_reg <= cfg_data[HALF_W-1:0];
                REG_HALF_Z: half_z_reg <= cfg_data[HALF_W-1:0];
                default:    ;
            endcase
        end
    end

    tbo_front #(.W(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .a_x        (a_x),
        .a_y        (a_y),
        .a_z        (a_z),
        .b_x        (b_x),
        .b_y        (b_y),
        .b_z        (b_z),
        .c_x        (c_x),
        .c_y        (c_y),
        .c_z        (c_z),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    tbo_queue #(.DATA_W(QW)) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    tbo_back #(.W(COORD_WIDTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_ready   (pop_ready),
        .q_data    (pop_data),
        .half_x    (half_x_reg),
        .half_y    (half_y_reg),
        .half_z    (half_z_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .overlap   (overlap)
    );

endmodule
